@@ hw/rtl/tal_pkg.sv @@
// Package for the temperature alarm block: payload structs, classified item,
// event and LED pattern codes, state codes and register indexes.
// No dependencies.
package tal_pkg;

  localparam int TEMP_WIDTH    = 16;
  localparam int CFG_IDX_WIDTH = 2;
  localparam int STATE_WIDTH   = 4;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_WIDTH    = $clog2(QUEUE_DEPTH);
  localparam int QCNT_WIDTH    = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes.
  localparam logic [CFG_IDX_WIDTH-1:0] REG_CRITICAL_HIGH = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_WARNING_HIGH  = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_CRITICAL_LOW  = 2'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_WARNING_LOW   = 2'd3;

  // Threshold reset values.
  localparam logic signed [TEMP_WIDTH-1:0] RST_CRITICAL_HIGH = 16'sd50;
  localparam logic signed [TEMP_WIDTH-1:0] RST_WARNING_HIGH  = 16'sd40;
  localparam logic signed [TEMP_WIDTH-1:0] RST_CRITICAL_LOW  = 16'sd0;
  localparam logic signed [TEMP_WIDTH-1:0] RST_WARNING_LOW   = 16'sd10;

  // Operation codes.
  localparam logic OP_EVALUATE = 1'b0;
  localparam logic OP_RESET    = 1'b1;

  // Alert event codes.
  localparam logic [1:0] ALERT_HI_WARN  = 2'd0;
  localparam logic [1:0] ALERT_LO_WARN  = 2'd1;
  localparam logic [1:0] ALERT_HI_ALARM = 2'd2;
  localparam logic [1:0] ALERT_LO_ALARM = 2'd3;

  // LED blink patterns.
  localparam logic [1:0] PAT_OFF  = 2'd0;
  localparam logic [1:0] PAT_DASH = 2'd1;
  localparam logic [1:0] PAT_DOT  = 2'd2;

  // Externally visible state codes.
  localparam logic [STATE_WIDTH-1:0] CODE_NORM1 = 4'd0;
  localparam logic [STATE_WIDTH-1:0] CODE_NORM2 = 4'd1;
  localparam logic [STATE_WIDTH-1:0] CODE_NORM3 = 4'd2;
  localparam logic [STATE_WIDTH-1:0] CODE_WLO1  = 4'd3;
  localparam logic [STATE_WIDTH-1:0] CODE_WLO2  = 4'd4;
  localparam logic [STATE_WIDTH-1:0] CODE_CLO   = 4'd5;
  localparam logic [STATE_WIDTH-1:0] CODE_WHI1  = 4'd6;
  localparam logic [STATE_WIDTH-1:0] CODE_WHI2  = 4'd7;
  localparam logic [STATE_WIDTH-1:0] CODE_CHI   = 4'd8;

  typedef struct packed {
    logic                         operation;
    logic signed [TEMP_WIDTH-1:0] temperature;
  } in_item_t;

  typedef struct packed {
    logic [STATE_WIDTH-1:0] machine_state;
    logic                   alert_valid;
    logic [1:0]             alert_code;
    logic                   blink_update;
    logic [1:0]             blink_pattern;
  } out_item_t;

  // A sample reduced to its operation and four threshold comparisons.
  typedef struct packed {
    logic operation;
    logic ge_warn_hi;
    logic le_warn_lo;
    logic le_crit_lo;
    logic ge_crit_hi;
  } class_t;

endpackage

@@ hw/rtl/temperature_alarm_fsm.sv @@
// Top level of the temperature alarm block: front classifier, queue and back
// state machine. Depends on tal_pkg, tal_front, tal_queue and tal_back.
//
//   Channel  Direction  Handshake            Contents
//   in_      input      in_valid / in_stall  operation, temperature
//   out_     output     out_valid/out_stall  state, alert, LED pattern
//   cfg_     input      cfg_we               threshold index and value
//
// One sample per cycle is taken while the queue is not full. Each result
// passes through the queue and then the output register: the comparisons
// enter the queue at the transfer edge, and the back part's state update
// reaches the output register when it pops that entry, which sets the rate.
// Reset (rst_n low at a clock edge) restores the thresholds and state 0 and
// empties the queue. A stall on the output fills the two-entry queue, after
// which in_stall rises; the front and back each stall independently.
module temperature_alarm_fsm (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  tal_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output tal_pkg::out_item_t                 out_data,
  input  logic                               cfg_we,
  input  logic [tal_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
  input  logic [tal_pkg::TEMP_WIDTH-1:0]     cfg_wdata
);
  import tal_pkg::*;

  logic   q_push, q_full, q_pop, q_valid;
  class_t q_wdata, q_rdata;

  tal_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  tal_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .full   (q_full),
    .pop    (q_pop),
    .rvalid (q_valid),
    .rdata  (q_rdata)
  );

  tal_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ hw/rtl/tal_front.sv @@
// Front part of the temperature alarm block: threshold registers, input
// transfer and classification of each sample. Depends on tal_pkg.
module tal_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  tal_pkg::in_item_t                   in_data,
  input  logic                                cfg_we,
  input  logic [tal_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
  input  logic [tal_pkg::TEMP_WIDTH-1:0]      cfg_wdata,
  input  logic                                q_full,
  output logic                                q_push,
  output tal_pkg::class_t                     q_wdata
);
  import tal_pkg::*;

  logic signed [TEMP_WIDTH-1:0] crit_hi_r, warn_hi_r, crit_lo_r, warn_lo_r;
  logic signed [TEMP_WIDTH-1:0] temp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crit_hi_r <= RST_CRITICAL_HIGH;
      warn_hi_r <= RST_WARNING_HIGH;
      crit_lo_r <= RST_CRITICAL_LOW;
      warn_lo_r <= RST_WARNING_LOW;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CRITICAL_HIGH: crit_hi_r <= $signed(cfg_wdata);
        REG_WARNING_HIGH:  warn_hi_r <= $signed(cfg_wdata);
        REG_CRITICAL_LOW:  crit_lo_r <= $signed(cfg_wdata);
        REG_WARNING_LOW:   warn_lo_r <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  assign temp     = $signed(in_data.temperature);
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_wdata.operation  = in_data.operation;
    q_wdata.ge_warn_hi = (temp >= warn_hi_r);
    q_wdata.le_warn_lo = (temp <= warn_lo_r);
    q_wdata.le_crit_lo = (temp <= crit_lo_r);
    q_wdata.ge_crit_hi = (temp >= crit_hi_r);
  end

endmodule

@@ hw/rtl/tal_queue.sv @@
// Two-entry queue of classified samples between the front and back parts.
// Depends on tal_pkg.
module tal_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  tal_pkg::class_t wdata,
  output logic            full,
  input  logic            pop,
  output logic            rvalid,
  output tal_pkg::class_t rdata
);
  import tal_pkg::*;

  class_t                entry_r [QUEUE_DEPTH];
  logic [QPTR_WIDTH-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_WIDTH-1:0] count_r, count_nxt;

  assign full   = (count_r == QCNT_WIDTH'(QUEUE_DEPTH));
  assign rvalid = (count_r != '0);
  assign rdata  = entry_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

@@ hw/rtl/tal_back.sv @@
// Back part of the temperature alarm block: the nine-state alarm machine and
// the output register that holds each result until its transfer. Depends on tal_pkg.
module tal_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  tal_pkg::class_t     q_rdata,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output tal_pkg::out_item_t  out_data
);
  import tal_pkg::*;

  typedef enum logic [8:0] {
    S_NORM1 = 9'b000000001,
    S_NORM2 = 9'b000000010,
    S_NORM3 = 9'b000000100,
    S_WLO1  = 9'b000001000,
    S_WLO2  = 9'b000010000,
    S_CLO   = 9'b000100000,
    S_WHI1  = 9'b001000000,
    S_WHI2  = 9'b010000000,
    S_CHI   = 9'b100000000
  } state_t;

  state_t     state_r, state_nxt;
  logic       out_valid_r;
  out_item_t  out_data_r;
  out_item_t  result;
  logic       av, bu;
  logic [1:0] ac, bp;
  logic [STATE_WIDTH-1:0] code;

  // The output register may take a new result when empty or when its
  // current result transfers in this cycle.
  assign q_pop     = q_valid && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt = state_r;
    av = 1'b0;
    ac = ALERT_HI_WARN;
    bu = 1'b0;
    bp = PAT_OFF;
    if (q_rdata.operation == OP_RESET) begin
      state_nxt = S_NORM1;
    end else begin
      unique case (state_r)
        S_NORM1: begin
          if (q_rdata.ge_warn_hi) begin
            av = 1'b1; ac = ALERT_HI_WARN; bu = 1'b1; bp = PAT_DASH; state_nxt = S_WHI1;
          end else if (q_rdata.le_warn_lo) begin
            av = 1'b1; ac = ALERT_LO_WARN; bu = 1'b1; bp = PAT_DASH; state_nxt = S_WLO1;
          end
        end
        S_NORM2: begin
          if (q_rdata.ge_warn_hi) begin
            av = 1'b1; ac = ALERT_HI_WARN; bu = 1'b1; bp = PAT_DASH; state_nxt = S_WHI2;
          end else if (q_rdata.le_warn_lo) begin
            bu = 1'b1; bp = PAT_DASH; state_nxt = S_WLO1;
          end
        end
        S_NORM3: begin
          if (q_rdata.ge_warn_hi) begin
            bu = 1'b1; bp = PAT_DASH; state_nxt = S_WHI1;
          end else if (q_rdata.le_warn_lo) begin
            av = 1'b1; ac = ALERT_LO_WARN; bu = 1'b1; bp = PAT_DASH; state_nxt = S_WLO1;
          end
        end
        S_WLO1: begin
          if (!q_rdata.le_warn_lo) begin
            bu = 1'b1; bp = PAT_OFF; state_nxt = S_NORM2;
          end else if (q_rdata.le_crit_lo) begin
            av = 1'b1; ac = ALERT_LO_ALARM; bu = 1'b1; bp = PAT_DOT; state_nxt = S_CLO;
          end
        end
        S_WLO2: begin
          if (!q_rdata.le_warn_lo) begin
            bu = 1'b1; bp = PAT_OFF; state_nxt = S_NORM2;
          end else if (q_rdata.le_crit_lo) begin
            bu = 1'b1; bp = PAT_DOT; state_nxt = S_CLO;
          end
        end
        S_CLO: begin
          if (!q_rdata.le_crit_lo) begin
            bu = 1'b1; bp = PAT_DASH; state_nxt = S_WLO2;
          end
        end
        S_WHI1: begin
          if (!q_rdata.ge_warn_hi) begin
            bu = 1'b1; bp = PAT_OFF; state_nxt = S_NORM3;
          end else if (q_rdata.ge_crit_hi) begin
            av = 1'b1; ac = ALERT_HI_ALARM; bu = 1'b1; bp = PAT_DOT; state_nxt = S_CHI;
          end
        end
        S_WHI2: begin
          if (!q_rdata.ge_warn_hi) begin
            bu = 1'b1; bp = PAT_OFF; state_nxt = S_NORM3;
          end else if (q_rdata.ge_crit_hi) begin
            bu = 1'b1; bp = PAT_DOT; state_nxt = S_CHI;
          end
        end
        S_CHI: begin
          if (!q_rdata.ge_crit_hi) begin
            bu = 1'b1; bp = PAT_DASH; state_nxt = S_WHI2;
          end
        end
        default: begin
          state_nxt = S_NORM1;
        end
      endcase
    end
  end

  always_comb begin
    unique case (state_nxt)
      S_NORM1: code = CODE_NORM1;
      S_NORM2: code = CODE_NORM2;
      S_NORM3: code = CODE_NORM3;
      S_WLO1:  code = CODE_WLO1;
      S_WLO2:  code = CODE_WLO2;
      S_CLO:   code = CODE_CLO;
      S_WHI1:  code = CODE_WHI1;
      S_WHI2:  code = CODE_WHI2;
      S_CHI:   code = CODE_CHI;
      default: code = CODE_NORM1;
    endcase
  end

  always_comb begin
    result.machine_state = code;
    result.alert_valid   = av;
    result.alert_code    = ac;
    result.blink_update  = bu;
    result.blink_pattern = bp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_NORM1;
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data_r <= result;
    end
  end

endmodule

@@ hw/rtl/tal_checker.sv @@
// Port-level checks for the temperature alarm block, and the bind that
// attaches them to the top level. Depends on tal_pkg and temperature_alarm_fsm.
module tal_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  tal_pkg::out_item_t                 out_data
);
  import tal_pkg::*;

  // A result held back by a stall must still be offered in the next cycle.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result withdrawn while stalled");

  // Nothing is offered in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered straight after reset");

  a_state_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.machine_state <= CODE_CHI))
    else $error("state code out of range");

  a_alert_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.alert_valid |-> (out_data.alert_code == ALERT_HI_WARN))
    else $error("alert code set without an alert");

  // Every alert comes with an LED change, and no change leaves the pattern off.
  a_blink_link: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.blink_update || (!out_data.alert_valid &&
                   out_data.blink_pattern == PAT_OFF)))
    else $error("alert or pattern without an LED update");

endmodule

bind temperature_alarm_fsm tal_checker u_tal_checker (.*);
